>>> rtl/sgl_pkg.sv
// Shared widths and reset constants for the sequence gap loss monitor.
package sgl_pkg;

	localparam int LEN_W = 11;
	localparam int SEQ_W = 16;
	localparam int CNT_W = 32;

	localparam logic [LEN_W-1:0] RST_EXPECTED_LENGTH = 11'd190;
	localparam logic [SEQ_W:0]   RST_MIN_CMD_SEQ     = 17'h1FFFF;

endpackage

>>> rtl/sgl_hist.sv
// Gap histogram: bin storage with read-modify-write across two pipeline stages.
module sgl_hist import sgl_pkg::*; #(
	parameter int HIST_BINS = 20,
	parameter int BIN_W     = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             lk_hit,
	input  logic [BIN_W-1:0] lk_bin,
	input  logic             upd_hit,
	input  logic [BIN_W-1:0] upd_bin,
	output logic [CNT_W-1:0] new_count
);

	logic [CNT_W-1:0] mem [HIST_BINS];
	logic [HIST_BINS-1:0] bin_vld_q;
	logic [CNT_W-1:0] rd_q;
	logic             rd_vld_q;
	logic             fwd_q;
	logic [CNT_W-1:0] last_q;
	logic [CNT_W-1:0] base;

	// bins not yet written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			rd_vld_q  <= 1'b0;
			fwd_q     <= 1'b0;
		end else if (adv) begin
			if (upd_hit) begin
				bin_vld_q[upd_bin] <= 1'b1;
			end
			rd_vld_q <= bin_vld_q[lk_bin];
			// read collides with the write of the item ahead: take its new count
			fwd_q    <= lk_hit && upd_hit && (lk_bin == upd_bin);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (upd_hit) begin
				mem[upd_bin] <= new_count;
			end
			rd_q   <= mem[lk_bin];
			last_q <= new_count;
		end
	end

	always_comb begin
		priority if (fwd_q) begin
			base = last_q;
		end else if (rd_vld_q) begin
			base = rd_q;
		end else begin
			base = '0;
		end
	end

	assign new_count = base + CNT_W'(1);

endmodule

>>> rtl/sequence_gap_loss_monitor.sv
// Top level of the sequence gap loss monitor.
// An accepted item passes the input register, the gap stage and the result register in
// that order. Throughput: one item per cycle unless a full result register stalls on out_ready low;
// the histogram read in the gap stage and its write in the next stage are forwarded.
// Reset (arst_n, async, active low): expected_length = 190, sequences unset,
// min command sequence all ones, totals and all histogram bins zero at once.
module sequence_gap_loss_monitor import sgl_pkg::*; #(
	parameter int HIST_BINS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [LEN_W-1:0]              cfg_data,
	// frame items in
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [LEN_W-1:0]              frame_length,
	input  logic [SEQ_W-1:0]              sensor_seq,
	input  logic [SEQ_W-1:0]              cmd_seq,
	// result items out
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          accepted,
	output logic [SEQ_W-1:0]              sensor_gap,
	output logic [CNT_W-1:0]              sensors_lost_total,
	output logic [CNT_W-1:0]              sensors_expected_total,
	output logic                          sensor_bin_hit,
	output logic [$clog2(HIST_BINS)-1:0]  sensor_bin,
	output logic [CNT_W-1:0]              sensor_bin_count,
	output logic signed [SEQ_W-1:0]       cmd_gap,
	output logic                          cmd_bin_hit,
	output logic [$clog2(HIST_BINS)-1:0]  cmd_bin,
	output logic [CNT_W-1:0]              cmd_bin_count,
	output logic [SEQ_W-1:0]              cmd_lost_total
);

	localparam int BIN_W = $clog2(HIST_BINS);
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HIST_BINS - 1);
	localparam logic [SEQ_W-1:0] BINS_SEQ = SEQ_W'(HIST_BINS);

	// ---------------------------------------------------------------
	// Global advance: the whole pipe moves when the result register is
	// empty or being drained. A new item is taken every such cycle.
	// ---------------------------------------------------------------
	logic adv;
	logic out_valid_q;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// Config register
	logic [LEN_W-1:0] expected_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_length_q <= RST_EXPECTED_LENGTH;
		end else if (cfg_valid) begin
			expected_length_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic             vld_s1;
	logic [LEN_W-1:0] len_s1;
	logic [SEQ_W-1:0] sseq_s1;
	logic [SEQ_W-1:0] cseq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			len_s1  <= frame_length;
			sseq_s1 <= sensor_seq;
			cseq_s1 <= cmd_seq;
		end
	end

	// ---------------------------------------------------------------
	// Gap logic on stage 1 against the running state
	// ---------------------------------------------------------------
	logic [SEQ_W-1:0] prev_sensor_q;
	logic [SEQ_W-1:0] prev_cmd_q;
	logic [SEQ_W:0]   min_cmd_q;
	logic [CNT_W-1:0] lost_q;
	logic [CNT_W-1:0] expected_q;

	logic             acc;
	logic             take;
	logic [SEQ_W-1:0] ps_eff;
	logic [SEQ_W-1:0] pc_eff;
	logic [SEQ_W-1:0] sgap;
	logic [SEQ_W-1:0] cgap;
	logic [SEQ_W:0]   min_next;
	logic [CNT_W-1:0] lost_next;
	logic [CNT_W-1:0] expected_next;
	logic             shit;
	logic             chit;
	logic [BIN_W-1:0] sbin;
	logic [BIN_W-1:0] cbin;
	logic [SEQ_W-1:0] cmd_lost;

	always_comb begin
		acc  = (len_s1 == expected_length_q);
		take = adv && vld_s1 && acc;
		// a stored sequence of zero is unset: seed it so the first gap is zero
		ps_eff = (prev_sensor_q == '0) ? (sseq_s1 - SEQ_W'(1)) : prev_sensor_q;
		pc_eff = (prev_cmd_q == '0) ? (cseq_s1 - SEQ_W'(1)) : prev_cmd_q;
		sgap   = sseq_s1 - ps_eff - SEQ_W'(1);
		cgap   = cseq_s1 - pc_eff - SEQ_W'(1);
		min_next = (min_cmd_q > {1'b0, cseq_s1}) ? {1'b0, cseq_s1} : min_cmd_q;
		lost_next     = lost_q + CNT_W'(sgap);
		expected_next = expected_q + CNT_W'(sgap) + CNT_W'(1);
		// gap g lands in bin g-1, large gaps in the last bin
		shit = (sgap != '0);
		sbin = (sgap <= BINS_SEQ) ? BIN_W'(sgap - SEQ_W'(1)) : LAST_BIN;
		// command gap counts only when positive as a signed value
		chit = (cgap != '0) && !cgap[SEQ_W-1];
		cbin = (cgap <= BINS_SEQ) ? BIN_W'(cgap - SEQ_W'(1)) : LAST_BIN;
		cmd_lost = cseq_s1 - min_next[SEQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sensor_q <= '0;
			prev_cmd_q    <= '0;
			min_cmd_q     <= RST_MIN_CMD_SEQ;
			lost_q        <= '0;
			expected_q    <= '0;
		end else if (take) begin
			prev_sensor_q <= sseq_s1;
			prev_cmd_q    <= cseq_s1;
			min_cmd_q     <= min_next;
			lost_q        <= lost_next;
			expected_q    <= expected_next;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: gap results, rejected frames carried as all zero
	// ---------------------------------------------------------------
	logic             vld_s2;
	logic             acc_s2;
	logic [SEQ_W-1:0] sgap_s2;
	logic [CNT_W-1:0] lost_s2;
	logic [CNT_W-1:0] expected_s2;
	logic             shit_s2;
	logic [BIN_W-1:0] sbin_s2;
	logic [SEQ_W-1:0] cgap_s2;
	logic             chit_s2;
	logic [BIN_W-1:0] cbin_s2;
	logic [SEQ_W-1:0] cmd_lost_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			acc_s2  <= 1'b0;
			shit_s2 <= 1'b0;
			chit_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2  <= vld_s1;
			acc_s2  <= vld_s1 && acc;
			shit_s2 <= vld_s1 && acc && shit;
			chit_s2 <= vld_s1 && acc && chit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sgap_s2     <= acc ? sgap : '0;
			lost_s2     <= acc ? lost_next : '0;
			expected_s2 <= acc ? expected_next : '0;
			sbin_s2     <= (acc && shit) ? sbin : '0;
			cgap_s2     <= acc ? cgap : '0;
			cbin_s2     <= (acc && chit) ? cbin : '0;
			cmd_lost_s2 <= acc ? cmd_lost : '0;
		end
	end

	// ---------------------------------------------------------------
	// Histograms: looked up from stage 1, updated from stage 2
	// ---------------------------------------------------------------
	logic [CNT_W-1:0] scount_s2;
	logic [CNT_W-1:0] ccount_s2;

	sgl_hist #(
		.HIST_BINS(HIST_BINS),
		.BIN_W    (BIN_W)
	) u_sensor_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.lk_hit   (vld_s1 && acc && shit),
		.lk_bin   (sbin),
		.upd_hit  (shit_s2),
		.upd_bin  (sbin_s2),
		.new_count(scount_s2)
	);

	sgl_hist #(
		.HIST_BINS(HIST_BINS),
		.BIN_W    (BIN_W)
	) u_cmd_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.lk_hit   (vld_s1 && acc && chit),
		.lk_bin   (cbin),
		.upd_hit  (chit_s2),
		.upd_bin  (cbin_s2),
		.new_count(ccount_s2)
	);

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic             acc_q;
	logic [SEQ_W-1:0] sgap_q;
	logic [CNT_W-1:0] lost_out_q;
	logic [CNT_W-1:0] expected_out_q;
	logic             shit_q;
	logic [BIN_W-1:0] sbin_q;
	logic [CNT_W-1:0] scount_q;
	logic [SEQ_W-1:0] cgap_q;
	logic             chit_q;
	logic [BIN_W-1:0] cbin_q;
	logic [CNT_W-1:0] ccount_q;
	logic [SEQ_W-1:0] cmd_lost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_q          <= acc_s2;
			sgap_q         <= sgap_s2;
			lost_out_q     <= lost_s2;
			expected_out_q <= expected_s2;
			shit_q         <= shit_s2;
			sbin_q         <= sbin_s2;
			scount_q       <= shit_s2 ? scount_s2 : '0;
			cgap_q         <= cgap_s2;
			chit_q         <= chit_s2;
			cbin_q         <= cbin_s2;
			ccount_q       <= chit_s2 ? ccount_s2 : '0;
			cmd_lost_q     <= cmd_lost_s2;
		end
	end

	assign accepted               = acc_q;
	assign sensor_gap             = sgap_q;
	assign sensors_lost_total     = lost_out_q;
	assign sensors_expected_total = expected_out_q;
	assign sensor_bin_hit         = shit_q;
	assign sensor_bin             = sbin_q;
	assign sensor_bin_count       = scount_q;
	assign cmd_gap                = cgap_q;
	assign cmd_bin_hit            = chit_q;
	assign cmd_bin                = cbin_q;
	assign cmd_bin_count          = ccount_q;
	assign cmd_lost_total         = cmd_lost_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> sensor_gap == '0 && !sensor_bin_hit && !cmd_bin_hit
			&& sensors_lost_total == '0 && cmd_lost_total == '0)
		else $error("rejected frame produced nonzero result");

	a_sensor_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sensor_bin_hit |-> accepted && sensor_gap != '0
			&& sensor_bin <= LAST_BIN)
		else $error("sensor bin hit without a positive gap");

	a_cmd_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_bin_hit |-> accepted && cmd_gap > 0 && cmd_bin <= LAST_BIN)
		else $error("command bin hit without a positive gap");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(lost_q) && $stable(expected_q) && $stable(prev_cmd_q))
		else $error("running state changed during a stall");

endmodule
